// ===== rtl/sdsbt_pkg.sv =====
`default_nettype none

package sdsbt_pkg;

  // Request function codes carried in the func field.
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_SLOT  = 2'd2;

  // Status codes reported with every result beat.
  localparam logic [3:0] ST_BUSY       = 4'd0;
  localparam logic [3:0] ST_BLOCK_OK   = 4'd1;
  localparam logic [3:0] ST_DONE       = 4'd2;
  localparam logic [3:0] ST_R1_ERROR   = 4'd3;
  localparam logic [3:0] ST_TOKEN_ERR  = 4'd4;
  localparam logic [3:0] ST_WR_REJECT  = 4'd5;
  localparam logic [3:0] ST_TIMEOUT    = 4'd6;
  localparam logic [3:0] ST_RANGE_ERR  = 4'd7;
  localparam logic [3:0] ST_NOT_USABLE = 4'd8;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BLOCK_SIZE_LOG2  = 2'd0;
  localparam logic [1:0] CFG_ACCESS_TIMEOUT   = 2'd1;
  localparam logic [1:0] CFG_CARD_BLOCK_COUNT = 2'd2;
  localparam logic [1:0] CFG_CARD_USABLE      = 2'd3;

  localparam logic [3:0]  BLOCK_LOG2_RESET     = 4'd9;
  localparam logic [23:0] ACCESS_TIMEOUT_RESET = 24'd4096;

  // SD protocol bytes and masks.
  localparam logic [7:0] CMD_READ_BYTE  = 8'h51;  // start bit plus CMD17
  localparam logic [7:0] CMD_WRITE_BYTE = 8'h58;  // start bit plus CMD24
  localparam logic [7:0] IDLE_BYTE      = 8'hFF;
  localparam logic [7:0] ZERO_BYTE      = 8'h00;
  localparam logic [7:0] DATA_TOKEN     = 8'hFE;
  localparam logic [7:0] R1_ERR_MASK    = 8'h7C;
  localparam logic [7:0] DRESP_MASK     = 8'h11;
  localparam logic [7:0] DRESP_MARK     = 8'h01;
  localparam logic [7:0] R1_RESET       = 8'hFF;
  localparam logic [6:0] CRC7_POLY      = 7'h09;

  localparam int R1_POLL_LIMIT       = 16;
  localparam int DATA_RESPONSE_POLLS = 4;
  localparam int CRC_BYTES           = 2;
  localparam int CMD_LAST_INDEX      = 5;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] start_block;
    logic [15:0] block_total;
    logic [7:0]  rx_byte;
    logic [7:0]  wr_byte;
  } item_t;

  typedef struct packed {
    logic [3:0]  block_size_log2;
    logic [23:0] access_timeout;
    logic [31:0] card_block_count;
    logic        card_usable;
  } cfg_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       chip_select;
    logic       slot_valid;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       wr_taken;
    logic [7:0] r1_value;
    logic [3:0] status;
  } result_t;

  // Block-size log2 limited to the supported 512..2048 byte range.
  function automatic logic [3:0] eff_log2(input logic [3:0] raw);
    logic [3:0] l;
    l = raw;
    if (l < 4'd9) l = 4'd9;
    if (l > 4'd11) l = 4'd11;
    return l;
  endfunction

  // Index of the last data byte in a block.
  function automatic logic [10:0] last_data_index(input logic [3:0] l);
    logic [10:0] r;
    case (l)
      4'd10:   r = 11'd1023;
      4'd11:   r = 11'd2047;
      default: r = 11'd511;
    endcase
    return r;
  endfunction

  // CRC7 advanced over one byte, most significant bit first.
  function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] data);
    logic [6:0] c;
    logic       fb;
    int         i;
    c = crc_in;
    for (i = 7; i >= 0; i--) begin
      fb = c[6] ^ data[i];
      c  = {c[5:0], 1'b0};
      if (fb) c = c ^ CRC7_POLY;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sdsbt_engine.sv =====
`default_nettype none

module sdsbt_engine (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire sdsbt_pkg::item_t item,
  input  wire sdsbt_pkg::cfg_t  cfg,
  output sdsbt_pkg::result_t    res
);
  import sdsbt_pkg::*;

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_PAD    = 4'd1;
  localparam logic [3:0] PH_CMD    = 4'd2;
  localparam logic [3:0] PH_R1     = 4'd3;
  localparam logic [3:0] PH_TOKEN  = 4'd4;
  localparam logic [3:0] PH_RDATA  = 4'd5;
  localparam logic [3:0] PH_RCRC   = 4'd6;
  localparam logic [3:0] PH_WTOKEN = 4'd7;
  localparam logic [3:0] PH_WDATA  = 4'd8;
  localparam logic [3:0] PH_WCRC   = 4'd9;
  localparam logic [3:0] PH_DRESP  = 4'd10;
  localparam logic [3:0] PH_BUSY   = 4'd11;

  logic [3:0]  phase, phase_next;
  logic        is_write, is_write_next;
  logic [10:0] byte_index, byte_index_next;
  logic [23:0] poll_count, poll_count_next;
  logic [31:0] current_block, current_block_next;
  logic [15:0] blocks_left, blocks_left_next;
  logic [39:0] frame, frame_next;       // command byte and byte address
  logic [6:0]  crc, crc_next;           // CRC7 over the frame bytes sent so far
  logic [7:0]  last_r1, last_r1_next;

  logic        do_finish, do_begin, do_block_done;
  logic [3:0]  fin_code;
  logic [31:0] begin_blk, begin_addr;
  logic        begin_wr;
  logic [7:0]  begin_cmd;
  logic [3:0]  eff_l;
  logic [10:0] last_idx;
  logic [32:0] range_end;

  always_comb begin
    phase_next         = phase;
    is_write_next      = is_write;
    byte_index_next    = byte_index;
    poll_count_next    = poll_count;
    current_block_next = current_block;
    blocks_left_next   = blocks_left;
    frame_next         = frame;
    crc_next           = crc;
    last_r1_next       = last_r1;

    res          = '0;
    res.tx_byte  = IDLE_BYTE;

    do_finish     = 1'b0;
    do_begin      = 1'b0;
    do_block_done = 1'b0;
    fin_code      = ST_BUSY;
    begin_blk     = current_block + 32'd1;
    begin_wr      = is_write;

    eff_l     = eff_log2(cfg.block_size_log2);
    last_idx  = last_data_index(eff_l);
    range_end = {1'b0, item.start_block} + {17'd0, item.block_total};

    case (phase)
      PH_IDLE: begin
        if (item.func == FUNC_READ || item.func == FUNC_WRITE) begin
          if (!cfg.card_usable) begin
            do_finish = 1'b1;
            fin_code  = ST_NOT_USABLE;
          end else if (range_end > {1'b0, cfg.card_block_count}) begin
            do_finish = 1'b1;
            fin_code  = ST_RANGE_ERR;
          end else if (item.block_total == 16'd0) begin
            do_finish = 1'b1;
            fin_code  = ST_DONE;
          end else begin
            is_write_next      = item.func[0];
            current_block_next = item.start_block;
            blocks_left_next   = item.block_total;
            begin_blk          = item.start_block;
            begin_wr           = item.func[0];
            do_begin           = 1'b1;
          end
        end
      end
      PH_PAD: begin
        phase_next      = PH_CMD;
        byte_index_next = '0;
        {res.tx_byte, res.chip_select, res.slot_valid} = {frame[39:32], 2'b11};
      end
      PH_CMD: begin
        if (byte_index < 11'(CMD_LAST_INDEX)) begin
          byte_index_next = byte_index + 11'd1;
          res.chip_select = 1'b1;
          res.slot_valid  = 1'b1;
          case (byte_index[2:0])
            3'd0: begin
              res.tx_byte = frame[31:24];
              crc_next    = crc7_byte(crc, frame[31:24]);
            end
            3'd1: begin
              res.tx_byte = frame[23:16];
              crc_next    = crc7_byte(crc, frame[23:16]);
            end
            3'd2: begin
              res.tx_byte = frame[15:8];
              crc_next    = crc7_byte(crc, frame[15:8]);
            end
            3'd3: begin
              res.tx_byte = frame[7:0];
              crc_next    = crc7_byte(crc, frame[7:0]);
            end
            default: res.tx_byte = {crc, 1'b1};
          endcase
        end else begin
          phase_next      = PH_R1;
          poll_count_next = 24'd1;
          {res.tx_byte, res.chip_select, res.slot_valid} = {IDLE_BYTE, 2'b11};
        end
      end
      PH_R1: begin
        last_r1_next = item.rx_byte;
        if (!item.rx_byte[7]) begin
          if ((item.rx_byte & R1_ERR_MASK) != 8'd0) begin
            do_finish = 1'b1;
            fin_code  = ST_R1_ERROR;
          end else if (is_write) begin
            phase_next = PH_WTOKEN;
            {res.tx_byte, res.chip_select, res.slot_valid} = {DATA_TOKEN, 2'b11};
          end else begin
            phase_next      = PH_TOKEN;
            poll_count_next = 24'd1;
            {res.tx_byte, res.chip_select, res.slot_valid} = {IDLE_BYTE, 2'b11};
          end
        end else if (poll_count >= 24'(R1_POLL_LIMIT)) begin
          do_finish = 1'b1;
          fin_code  = ST_TIMEOUT;
        end else begin
          poll_count_next = poll_count + 24'd1;
          {res.tx_byte, res.chip_select, res.slot_valid} = {IDLE_BYTE, 2'b11};
        end
      end
      PH_TOKEN: begin
        if (item.rx_byte == DATA_TOKEN) begin
          phase_next      = PH_RDATA;
          byte_index_next = '0;
          {res.tx_byte, res.chip_select, res.slot_valid} = {IDLE_BYTE, 2'b11};
        end else if (item.rx_byte != IDLE_BYTE) begin
          do_finish = 1'b1;
          fin_code  = ST_TOKEN_ERR;
        end else if (poll_count >= cfg.access_timeout) begin
          do_finish = 1'b1;
          fin_code  = ST_TIMEOUT;
        end else begin
          poll_count_next = poll_count + 24'd1;
          {res.tx_byte, res.chip_select, res.slot_valid} = {IDLE_BYTE, 2'b11};
        end
      end
      PH_RDATA: begin
        res.rd_byte  = item.rx_byte;
        res.rd_valid = 1'b1;
        if (byte_index != last_idx) begin
          byte_index_next = byte_index + 11'd1;
        end else begin
          phase_next      = PH_RCRC;
          byte_index_next = '0;
        end
        {res.tx_byte, res.chip_select, res.slot_valid} = {IDLE_BYTE, 2'b11};
      end
      PH_RCRC: begin
        if (byte_index < 11'(CRC_BYTES - 1)) begin
          byte_index_next = byte_index + 11'd1;
          {res.tx_byte, res.chip_select, res.slot_valid} = {IDLE_BYTE, 2'b11};
        end else begin
          do_block_done = 1'b1;
        end
      end
      PH_WTOKEN: begin
        phase_next      = PH_WDATA;
        byte_index_next = '0;
        res.wr_taken    = 1'b1;
        {res.tx_byte, res.chip_select, res.slot_valid} = {item.wr_byte, 2'b11};
      end
      PH_WDATA: begin
        if (byte_index != last_idx) begin
          byte_index_next = byte_index + 11'd1;
          res.wr_taken    = 1'b1;
          {res.tx_byte, res.chip_select, res.slot_valid} = {item.wr_byte, 2'b11};
        end else begin
          phase_next      = PH_WCRC;
          byte_index_next = '0;
          {res.tx_byte, res.chip_select, res.slot_valid} = {ZERO_BYTE, 2'b11};
        end
      end
      PH_WCRC: begin
        if (byte_index < 11'(CRC_BYTES - 1)) begin
          byte_index_next = byte_index + 11'd1;
          {res.tx_byte, res.chip_select, res.slot_valid} = {ZERO_BYTE, 2'b11};
        end else begin
          phase_next      = PH_DRESP;
          poll_count_next = 24'd1;
          {res.tx_byte, res.chip_select, res.slot_valid} = {IDLE_BYTE, 2'b11};
        end
      end
      PH_DRESP: begin
        if ((item.rx_byte & DRESP_MASK) == DRESP_MARK) begin
          if (item.rx_byte[3]) begin
            do_finish = 1'b1;
            fin_code  = ST_WR_REJECT;
          end else begin
            phase_next      = PH_BUSY;
            poll_count_next = 24'd1;
            {res.tx_byte, res.chip_select, res.slot_valid} = {IDLE_BYTE, 2'b11};
          end
        end else if (poll_count >= 24'(DATA_RESPONSE_POLLS)) begin
          do_finish = 1'b1;
          fin_code  = ST_TIMEOUT;
        end else begin
          poll_count_next = poll_count + 24'd1;
          {res.tx_byte, res.chip_select, res.slot_valid} = {IDLE_BYTE, 2'b11};
        end
      end
      PH_BUSY: begin
        if (item.rx_byte != ZERO_BYTE) begin
          do_block_done = 1'b1;
        end else if (poll_count >= cfg.access_timeout) begin
          do_finish = 1'b1;
          fin_code  = ST_TIMEOUT;
        end else begin
          poll_count_next = poll_count + 24'd1;
          {res.tx_byte, res.chip_select, res.slot_valid} = {IDLE_BYTE, 2'b11};
        end
      end
      default: begin
        do_finish = 1'b1;
        fin_code  = ST_BUSY;
      end
    endcase

    // End of a block: either the request is complete or the next block starts.
    if (do_block_done) begin
      current_block_next = current_block + 32'd1;
      blocks_left_next   = blocks_left - 16'd1;
      if (blocks_left_next == 16'd0) begin
        do_finish = 1'b1;
        fin_code  = ST_DONE;
      end else begin
        do_begin   = 1'b1;
        res.status = ST_BLOCK_OK;
      end
    end

    // Build the command for a new block and send the deselected pad byte.
    begin_addr = begin_blk << eff_l;
    begin_cmd  = begin_wr ? CMD_WRITE_BYTE : CMD_READ_BYTE;
    if (do_begin) begin
      frame_next = {begin_cmd, begin_addr};
      crc_next   = crc7_byte(7'd0, begin_cmd);
      phase_next = PH_PAD;
      {res.tx_byte, res.chip_select, res.slot_valid} = {IDLE_BYTE, 2'b01};
    end

    if (do_finish) begin
      phase_next = PH_IDLE;
      res.tx_byte     = IDLE_BYTE;
      res.chip_select = 1'b0;
      res.slot_valid  = 1'b0;
      res.status      = fin_code;
    end

    res.r1_value = last_r1_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      last_r1 <= R1_RESET;
    end else if (step) begin
      phase   <= phase_next;
      last_r1 <= last_r1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      is_write      <= is_write_next;
      byte_index    <= byte_index_next;
      poll_count    <= poll_count_next;
      current_block <= current_block_next;
      blocks_left   <= blocks_left_next;
      frame         <= frame_next;
      crc           <= crc_next;
    end
  end

`ifndef SYNTHESIS
  // A slot is requested exactly when the sequencer leaves a transfer running.
  a_slot_matches_phase: assert property (@(posedge clk) disable iff (rst)
    step |=> ((phase != PH_IDLE) == $past(res.slot_valid)))
    else $error("slot request disagrees with the next phase");

  // Any final status returns the sequencer to idle.
  a_final_status_idles: assert property (@(posedge clk) disable iff (rst)
    (step && res.status != ST_BUSY && res.status != ST_BLOCK_OK) |=> (phase == PH_IDLE))
    else $error("final status given without returning to idle");

  // Write data is consumed only in a selected slot.
  a_wr_taken_selected: assert property (@(posedge clk) disable iff (rst)
    res.wr_taken |-> (res.chip_select && res.slot_valid && is_write))
    else $error("write byte consumed outside a selected write slot");

  // Read data appears only while receiving block bytes.
  a_rd_valid_phase: assert property (@(posedge clk) disable iff (rst)
    res.rd_valid |-> (phase == PH_RDATA && !is_write))
    else $error("read byte flagged outside the read data phase");
`endif

endmodule

`default_nettype wire

// ===== rtl/sd_spi_block_transfer_sequencer_unit.sv =====
// Path: a beat is accepted into the input register, processed by the step logic, and
//   its result beat is held in the result register and offered from there.
// Throughput: one beat per cycle while the output side is free; the input register and
//   the result register keep taking beats as long as the output side stays free.
// Reset (rst, synchronous, active high): sequencer idle, no beats held, last R1 0xFF,
//   block size log2 9, access timeout 4096, card block count 0, card not usable.
`default_nettype none

module sd_spi_block_transfer_sequencer_unit (
  input  wire logic        clk,
  input  wire logic        rst,

  // Configuration write port.
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,

  // Input channel: one beat per SPI byte slot, or a start request.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [31:0] start_block,
  input  wire logic [15:0] block_total,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [7:0]  wr_byte,

  // Output channel: one result beat for each input beat.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       tx_byte,
  output logic             chip_select,
  output logic             slot_valid,
  output logic [7:0]       rd_byte,
  output logic             rd_valid,
  output logic             wr_taken,
  output logic [7:0]       r1_value,
  output logic [3:0]       status
);
  import sdsbt_pkg::*;

  // Configuration registers. They must be written by the user only while the sequencer is idle,
  // so the step logic may read them directly; the block itself does not enforce this.
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_size_log2  <= BLOCK_LOG2_RESET;
      cfg.access_timeout   <= ACCESS_TIMEOUT_RESET;
      cfg.card_block_count <= '0;
      cfg.card_usable      <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BLOCK_SIZE_LOG2:  cfg.block_size_log2  <= cfg_data[3:0];
        CFG_ACCESS_TIMEOUT:   cfg.access_timeout   <= cfg_data[23:0];
        CFG_CARD_BLOCK_COUNT: cfg.card_block_count <= cfg_data;
        CFG_CARD_USABLE:      cfg.card_usable      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register. It refills in the same cycle that its beat moves on, so the
  // input side keeps streaming while the result register is free or draining.
  item_t   in_q;
  logic    in_q_valid;
  logic    step;
  result_t res;
  result_t out_q;

  assign step     = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= '{func: func, start_block: start_block, block_total: block_total,
                rx_byte: rx_byte, wr_byte: wr_byte};
    end
  end

  // The engine holds the transfer state and turns one beat into one result.
  sdsbt_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_q),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register: holds a finished beat until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign tx_byte     = out_q.tx_byte;
  assign chip_select = out_q.chip_select;
  assign slot_valid  = out_q.slot_valid;
  assign rd_byte     = out_q.rd_byte;
  assign rd_valid    = out_q.rd_valid;
  assign wr_taken    = out_q.wr_taken;
  assign r1_value    = out_q.r1_value;
  assign status      = out_q.status;

endmodule

`default_nettype wire
